### hdl/vtp_pkg.sv
// Shared types, action codes and byte constants for the VT100 escape sequence parser.
// Used by vtp_decode and vt100_escape_sequence_parser; depends on nothing.
package vtp_pkg;

    localparam int ACT_W  = 5;
    localparam int BYTE_W = 8;
    localparam int VAL_W  = 16;

    localparam logic [ACT_W-1:0] ACT_NONE   = 5'd0;
    localparam logic [ACT_W-1:0] ACT_PRINT  = 5'd0;
    localparam logic [ACT_W-1:0] ACT_BEL    = 5'd1;
    localparam logic [ACT_W-1:0] ACT_BS     = 5'd2;
    localparam logic [ACT_W-1:0] ACT_HT     = 5'd3;
    localparam logic [ACT_W-1:0] ACT_LF     = 5'd4;
    localparam logic [ACT_W-1:0] ACT_CR     = 5'd5;
    localparam logic [ACT_W-1:0] ACT_SO     = 5'd6;
    localparam logic [ACT_W-1:0] ACT_SI     = 5'd7;
    localparam logic [ACT_W-1:0] ACT_SUB    = 5'd8;
    localparam logic [ACT_W-1:0] ACT_ESC_SC = 5'd9;
    localparam logic [ACT_W-1:0] ACT_ESC_RC = 5'd10;
    localparam logic [ACT_W-1:0] ACT_ESC_IND = 5'd11;
    localparam logic [ACT_W-1:0] ACT_ESC_NEL = 5'd12;
    localparam logic [ACT_W-1:0] ACT_ESC_RI = 5'd13;
    localparam logic [ACT_W-1:0] ACT_ESC_RIS = 5'd14;
    localparam logic [ACT_W-1:0] ACT_CUU    = 5'd15;
    localparam logic [ACT_W-1:0] ACT_CUD    = 5'd16;
    localparam logic [ACT_W-1:0] ACT_CUF    = 5'd17;
    localparam logic [ACT_W-1:0] ACT_CUB    = 5'd18;
    localparam logic [ACT_W-1:0] ACT_CUP    = 5'd19;
    localparam logic [ACT_W-1:0] ACT_ED     = 5'd20;
    localparam logic [ACT_W-1:0] ACT_EL     = 5'd21;
    localparam logic [ACT_W-1:0] ACT_DA     = 5'd22;
    localparam logic [ACT_W-1:0] ACT_SM     = 5'd23;
    localparam logic [ACT_W-1:0] ACT_RM     = 5'd24;
    localparam logic [ACT_W-1:0] ACT_SGR    = 5'd25;
    localparam logic [ACT_W-1:0] ACT_DSR    = 5'd26;
    localparam logic [ACT_W-1:0] ACT_STBM   = 5'd27;

    localparam logic [BYTE_W-1:0] CH_BEL   = 8'h07;
    localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CH_HT    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SO    = 8'h0E;
    localparam logic [BYTE_W-1:0] CH_SI    = 8'h0F;
    localparam logic [BYTE_W-1:0] CH_CAN   = 8'h18;
    localparam logic [BYTE_W-1:0] CH_SUB   = 8'h1A;
    localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_C0_MAX = 8'h1F;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_INT_MAX = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_QUEST = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_FINAL_MIN = 8'h40;
    localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;

    typedef struct packed {
        logic              emit;
        logic [ACT_W-1:0]  act;
        logic              clear_seq;
        logic              start_esc;
        logic              set_inter;
        logic              open_csi;
        logic              clear_fresh;
        logic              set_private;
        logic              digit;
        logic              semi;
        logic              csi_final;
    } dec_t;

    function automatic logic [ACT_W-1:0] csi_code(input logic [BYTE_W-1:0] c);
        logic [ACT_W-1:0] a;
        a = ACT_NONE;
        case (c)
            8'h41: a = ACT_CUU;
            8'h42: a = ACT_CUD;
            8'h43: a = ACT_CUF;
            8'h44: a = ACT_CUB;
            8'h48, 8'h66: a = ACT_CUP;
            8'h4A: a = ACT_ED;
            8'h4B: a = ACT_EL;
            8'h63: a = ACT_DA;
            8'h68: a = ACT_SM;
            8'h6C: a = ACT_RM;
            8'h6D: a = ACT_SGR;
            8'h6E: a = ACT_DSR;
            8'h72: a = ACT_STBM;
            default: a = ACT_NONE;
        endcase
        return a;
    endfunction

    function automatic logic [ACT_W-1:0] esc_code(input logic [BYTE_W-1:0] c);
        logic [ACT_W-1:0] a;
        a = ACT_NONE;
        case (c)
            8'h37: a = ACT_ESC_SC;
            8'h38: a = ACT_ESC_RC;
            8'h44: a = ACT_ESC_IND;
            8'h45: a = ACT_ESC_NEL;
            8'h4D: a = ACT_ESC_RI;
            8'h63: a = ACT_ESC_RIS;
            default: a = ACT_NONE;
        endcase
        return a;
    endfunction

endpackage

### hdl/vtp_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies; contents are undefined until written.
module vtp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/vtp_decode.sv
// Byte classifier of the escape sequence parser: turns one byte and the sequence flags
// into a set of state updates and an optional result. Depends on vtp_pkg.
module vtp_decode (
    input  logic                        enable,
    input  logic [vtp_pkg::BYTE_W-1:0]  rx_byte,
    input  logic                        in_escape,
    input  logic                        in_csi,
    input  logic                        csi_fresh,
    input  logic                        inter_seen,
    output vtp_pkg::dec_t               dec
);
    import vtp_pkg::*;

    logic is_ctrl;

    assign is_ctrl = (rx_byte <= CH_C0_MAX) || (rx_byte == CH_DEL);

    always_comb begin
        dec = '0;
        if (!enable) begin
            dec.emit = 1'b1;
            dec.act  = ACT_PRINT;
        end else if (is_ctrl) begin
            unique case (rx_byte) inside
                CH_BEL: begin
                    dec.emit = 1'b1;
                    dec.act  = ACT_BEL;
                end
                CH_BS: begin
                    dec.emit = 1'b1;
                    dec.act  = ACT_BS;
                end
                CH_HT: begin
                    dec.emit = 1'b1;
                    dec.act  = ACT_HT;
                end
                CH_LF, CH_VT, CH_FF: begin
                    dec.emit = 1'b1;
                    dec.act  = ACT_LF;
                end
                CH_CR: begin
                    dec.emit = 1'b1;
                    dec.act  = ACT_CR;
                end
                CH_SO: begin
                    dec.emit = 1'b1;
                    dec.act  = ACT_SO;
                end
                CH_SI: begin
                    dec.emit = 1'b1;
                    dec.act  = ACT_SI;
                end
                CH_SUB: begin
                    dec.emit      = 1'b1;
                    dec.act       = ACT_SUB;
                    dec.clear_seq = 1'b1;
                end
                CH_CAN: begin
                    dec.clear_seq = 1'b1;
                end
                CH_ESC: begin
                    dec.clear_seq = 1'b1;
                    dec.start_esc = 1'b1;
                end
                default: begin
                end
            endcase
        end else if (rx_byte[BYTE_W-1]) begin
            dec = '0;
        end else if (!in_escape) begin
            dec.emit = 1'b1;
            dec.act  = ACT_PRINT;
        end else if (in_csi) begin
            dec.clear_fresh = 1'b1;
            if (rx_byte == CH_QUEST && csi_fresh) begin
                dec.set_private = 1'b1;
            end else if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE) begin
                dec.digit = 1'b1;
            end else if (rx_byte == CH_SEMI) begin
                dec.semi = 1'b1;
            end else if (rx_byte < CH_FINAL_MIN) begin
                dec.clear_seq = 1'b1;
            end else begin
                dec.csi_final = (csi_code(rx_byte) != ACT_NONE);
                dec.act       = csi_code(rx_byte);
                dec.clear_seq = 1'b1;
            end
        end else if (rx_byte >= CH_SPACE && rx_byte <= CH_INT_MAX) begin
            dec.set_inter = 1'b1;
        end else if (!inter_seen && rx_byte == CH_LBRACKET) begin
            dec.open_csi = 1'b1;
        end else begin
            dec.clear_seq = 1'b1;
            dec.act       = inter_seen ? ACT_NONE : esc_code(rx_byte);
            dec.emit      = !inter_seen && (esc_code(rx_byte) != ACT_NONE);
        end
    end

endmodule

### hdl/vt100_escape_sequence_parser.sv
// A byte is taken in state ST_IDLE and decoded in ST_EXEC; the next byte is not taken until it is decoded.
// For a CSI command with parameters, each parameter then passes through ST_EMIT_RD, the RAM
// read of the parameter, and ST_EMIT_OUT, which loads it into the output register; output
// stalls hold ST_EXEC and ST_EMIT_OUT. A CSI command with parameters holds off the input
// until its last beat is loaded into the output register.
// Reset is synchronous and active low; it clears all sequence state and sets decoding on.
// The parameter RAM is not cleared: every entry is written before its value is used.
module vt100_escape_sequence_parser #(
    parameter int MAX_PARAMS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,            // ansi_enable
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,                // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // action, char_code, private_mode, param_count, param_index, param_value, zero fill
    output logic [((vtp_pkg::ACT_W + vtp_pkg::BYTE_W + 1 + $clog2(MAX_PARAMS + 1)
                   + $clog2(MAX_PARAMS) + vtp_pkg::VAL_W + 7) / 8) * 8 - 1:0] m_tdata,
    output logic        m_tlast                 // last
);
    import vtp_pkg::*;

    localparam int AW   = $clog2(MAX_PARAMS);
    localparam int CW   = $clog2(MAX_PARAMS + 1);
    localparam int PW   = ACT_W + BYTE_W + 1 + CW + AW + VAL_W;
    localparam int DW   = ((PW + 7) / 8) * 8;
    localparam int PROD_W = VAL_W + 4;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_EXEC    = 2'd1;
    localparam logic [1:0] ST_EMIT_RD = 2'd2;
    localparam logic [1:0] ST_EMIT_OUT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic              enable_reg;
    logic [7:0]        byte_reg;
    logic              in_escape_reg, in_escape_next;
    logic              in_csi_reg, in_csi_next;
    logic              csi_fresh_reg, csi_fresh_next;
    logic              private_reg, private_next;
    logic              inter_reg, inter_next;
    logic [AW-1:0]     total_reg, total_next;
    logic              started_reg, started_next;
    logic              tail_reg, tail_next;

    logic [ACT_W-1:0]  emit_act_reg, emit_act_next;
    logic [7:0]        emit_char_reg, emit_char_next;
    logic              emit_pm_reg, emit_pm_next;
    logic [CW-1:0]     emit_cnt_reg, emit_cnt_next;
    logic [AW-1:0]     emit_idx_reg, emit_idx_next;

    logic              out_valid_reg, out_valid_next;
    logic [PW-1:0]     out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;

    logic              ram_wr_en, ram_rd_en;
    logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
    logic [VAL_W-1:0]  ram_wr_data, ram_rd_data;

    dec_t              dec;
    logic              out_free, in_accept, needs_out, go;
    logic [CW-1:0]     cnt;
    logic [PROD_W-1:0] prod;
    logic              emit_last;

    vtp_decode u_decode (
        .enable     (enable_reg),
        .rx_byte    (byte_reg),
        .in_escape  (in_escape_reg),
        .in_csi     (in_csi_reg),
        .csi_fresh  (csi_fresh_reg),
        .inter_seen (inter_reg),
        .dec        (dec)
    );

    vtp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_PARAMS)
    ) u_param_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign cnt       = CW'(total_reg) + CW'(started_reg);
    assign needs_out = dec.emit || (dec.csi_final && cnt == '0);
    assign go        = out_free || !needs_out;
    assign prod      = {ram_rd_data, 3'b000} + {2'b00, ram_rd_data, 1'b0}
                       + PROD_W'(byte_reg[3:0]);
    assign emit_last = (CW'(emit_idx_reg) + CW'(1)) == emit_cnt_reg;

    assign ram_rd_en   = in_accept || (state_reg == ST_EMIT_RD);
    assign ram_rd_addr = (state_reg == ST_EMIT_RD) ? emit_idx_reg : total_reg;

    always_comb begin
        state_next     = state_reg;
        in_escape_next = in_escape_reg;
        in_csi_next    = in_csi_reg;
        csi_fresh_next = csi_fresh_reg;
        private_next   = private_reg;
        inter_next     = inter_reg;
        total_next     = total_reg;
        started_next   = started_reg;
        tail_next      = tail_reg;
        emit_act_next  = emit_act_reg;
        emit_char_next = emit_char_reg;
        emit_pm_next   = emit_pm_reg;
        emit_cnt_next  = emit_cnt_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = total_reg;
        ram_wr_data    = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (go) begin
                    state_next = ST_IDLE;
                    if (dec.emit) begin
                        out_valid_next = 1'b1;
                        out_data_next  = {VAL_W'(0), AW'(0), CW'(0), 1'b0, byte_reg, dec.act};
                        out_last_next  = 1'b1;
                    end
                    if (dec.clear_fresh) begin
                        csi_fresh_next = 1'b0;
                    end
                    if (dec.set_private) begin
                        private_next = 1'b1;
                    end
                    if (dec.set_inter) begin
                        inter_next = 1'b1;
                    end
                    if (dec.digit) begin
                        started_next = 1'b1;
                        if (!tail_reg) begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = total_reg;
                            ram_wr_data = (prod > PROD_W'(16'hFFFF)) ? 16'hFFFF
                                                                     : prod[VAL_W-1:0];
                        end
                    end
                    if (dec.semi) begin
                        if (total_reg < AW'(MAX_PARAMS - 1)) begin
                            total_next   = total_reg + AW'(1);
                            started_next = 1'b0;
                            ram_wr_en    = 1'b1;
                            ram_wr_addr  = total_reg + AW'(1);
                            ram_wr_data  = '0;
                        end else begin
                            started_next = 1'b1;
                            tail_next    = 1'b1;
                        end
                    end
                    if (dec.open_csi) begin
                        in_csi_next    = 1'b1;
                        csi_fresh_next = 1'b1;
                        total_next     = '0;
                        started_next   = 1'b0;
                        tail_next      = 1'b0;
                        ram_wr_en      = 1'b1;
                        ram_wr_addr    = '0;
                        ram_wr_data    = '0;
                    end
                    if (dec.csi_final) begin
                        if (cnt == '0) begin
                            out_valid_next = 1'b1;
                            out_data_next  = {VAL_W'(0), AW'(0), CW'(0), private_reg,
                                              byte_reg, dec.act};
                            out_last_next  = 1'b1;
                        end else begin
                            state_next     = ST_EMIT_RD;
                            emit_act_next  = dec.act;
                            emit_char_next = byte_reg;
                            emit_pm_next   = private_reg;
                            emit_cnt_next  = cnt;
                            emit_idx_next  = '0;
                        end
                    end
                    if (dec.clear_seq) begin
                        in_escape_next = 1'b0;
                        in_csi_next    = 1'b0;
                        csi_fresh_next = 1'b0;
                        private_next   = 1'b0;
                        inter_next     = 1'b0;
                        total_next     = '0;
                        started_next   = 1'b0;
                        tail_next      = 1'b0;
                    end
                    if (dec.start_esc) begin
                        in_escape_next = 1'b1;
                    end
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {ram_rd_data, emit_idx_reg, emit_cnt_reg, emit_pm_reg,
                                      emit_char_reg, emit_act_reg};
                    out_last_next  = emit_last;
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        emit_idx_next = emit_idx_reg + AW'(1);
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            enable_reg    <= 1'b1;
            in_escape_reg <= 1'b0;
            in_csi_reg    <= 1'b0;
            csi_fresh_reg <= 1'b0;
            private_reg   <= 1'b0;
            inter_reg     <= 1'b0;
            total_reg     <= '0;
            started_reg   <= 1'b0;
            tail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_wr_en) begin
                enable_reg <= cfg_wr_data;
            end
            in_escape_reg <= in_escape_next;
            in_csi_reg    <= in_csi_next;
            csi_fresh_reg <= csi_fresh_next;
            private_reg   <= private_next;
            inter_reg     <= inter_next;
            total_reg     <= total_next;
            started_reg   <= started_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            byte_reg <= s_tdata;
        end
        emit_act_reg  <= emit_act_next;
        emit_char_reg <= emit_char_next;
        emit_pm_reg   <= emit_pm_next;
        emit_cnt_reg  <= emit_cnt_next;
        emit_idx_reg  <= emit_idx_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DW'(out_data_reg);
    assign m_tlast  = out_last_reg;

endmodule
